@@ hdl/lesf_pkg.sv @@
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared widths and defaults for the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int COLS_W       = 9;
    localparam int SIZE_W       = 8;
    localparam int ROW_W        = 7;
    localparam int COL_W        = 8;
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 128;

    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(256);
    localparam logic [SIZE_W-1:0] SIZE_SAT   = {SIZE_W{1'b1}};

endpackage

@@ hdl/lesf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lesf_cfg_if
// Write channel for the column count register.
// ----------------------------------------------------------------------------
interface lesf_cfg_if
    import lesf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COLS_W-1:0] columns;

    modport source (output valid, output columns, input ready);
    modport sink   (input valid, input columns, output ready);
endinterface

@@ hdl/lesf_cell_if.sv @@
// ----------------------------------------------------------------------------
// lesf_cell_if
// Map cell channel, one cell per beat in raster order.
// ----------------------------------------------------------------------------
interface lesf_cell_if;
    logic valid;
    logic ready;
    logic blocked;
    logic last_cell;

    modport source (output valid, output blocked, output last_cell, input ready);
    modport sink   (input valid, input blocked, input last_cell, output ready);
endinterface

@@ hdl/lesf_result_if.sv @@
// ----------------------------------------------------------------------------
// lesf_result_if
// Result channel, one beat per finished map.
// ----------------------------------------------------------------------------
interface lesf_result_if
    import lesf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] square_size;
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  left_col;
    logic              too_large;

    modport source (output valid, output square_size, output top_row,
                    output left_col, output too_large, input ready);
    modport sink   (input valid, input square_size, input top_row,
                    input left_col, input too_large, output ready);
endinterface

@@ hdl/lesf_ram.sv @@
// ----------------------------------------------------------------------------
// lesf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/largest_empty_square_finder.sv @@
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Finds the largest all-empty square in a binary map streamed in raster order.
// ----------------------------------------------------------------------------
// Takes one map cell per clock cycle, back to back, and keeps one line of
// square sides in a single RAM of MAX_COLS entries. The line RAM is read when
// a cell is accepted and written when the min-of-three step runs, as the cell
// leaves the stage register; the result of a map is registered as its last
// cell leaves the stage register and may wait in the output register while
// the next map streams in. The input stalls only when the next map's last
// cell sits in the stage register while the previous result still waits. Ties
// keep the top-most, then left-most square. Rows past MAX_ROWS only set
// too_large. The column count may be written only while the block is idle.
// ----------------------------------------------------------------------------
module largest_empty_square_finder
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lesf_cfg_if.sink      i_cfg,
    lesf_cell_if.sink     i_cell,
    lesf_result_if.source o_result
);

    localparam int CIW   = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    // configuration and stream counters
    logic [COLS_W-1:0] r_columns;
    logic [CIW-1:0]    r_col_count, n_col_count;
    logic [RW-1:0]     r_row_count, n_row_count;
    logic [CNT_W-1:0]  v_eff_cols;

    // stage one
    logic              r_s1_valid;
    logic              r_s1_blocked;
    logic              r_s1_last;
    logic [CIW-1:0]    r_s1_col;
    logic [RW-1:0]     r_s1_row;
    logic              r_byp;
    logic [SIZE_W-1:0] r_fwd;

    // map state
    logic [SIZE_W-1:0] r_left_size;
    logic [SIZE_W-1:0] r_diag_size;
    logic [SIZE_W-1:0] r_best_size;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;
    logic              r_overflow;

    // output register
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_size;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_ovf;

    logic              v_accept;
    logic              v_s1_fire;
    logic              v_s1_ovf;
    logic              v_we;
    logic [SIZE_W-1:0] v_ram_rdata;
    logic [SIZE_W-1:0] v_up, v_dg, v_lf, v_min, v_side;
    logic              v_better;
    logic [SIZE_W-1:0] n_best_size;
    logic [ROW_W-1:0]  n_best_row;
    logic [COL_W-1:0]  n_best_col;
    logic              n_overflow;
    logic [31:0]       v_row_calc, v_col_calc;

    assign i_cfg.ready = 1'b1;

    assign v_s1_fire = r_s1_valid && (!r_s1_last || !r_out_valid || o_result.ready);
    assign i_cell.ready = !r_s1_valid || v_s1_fire;
    assign v_accept = i_cell.valid && i_cell.ready;

    always_comb begin
        if (r_columns == '0) begin
            v_eff_cols = CNT_W'(1);
        end else if (32'(r_columns) > MAX_COLS) begin
            v_eff_cols = CNT_W'(MAX_COLS);
        end else begin
            v_eff_cols = CNT_W'(r_columns);
        end
    end

    always_comb begin
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        if (v_accept) begin
            if (i_cell.last_cell) begin
                n_col_count = '0;
                n_row_count = '0;
            end else if (32'(r_col_count) + 32'd1 >= 32'(v_eff_cols)) begin
                n_col_count = '0;
                if (32'(r_row_count) < MAX_ROWS) begin
                    n_row_count = r_row_count + RW'(1);
                end
            end else begin
                n_col_count = r_col_count + CIW'(1);
            end
        end
    end

    // min-of-three step
    assign v_s1_ovf = 32'(r_s1_row) >= MAX_ROWS;
    assign v_we     = v_s1_fire && !v_s1_ovf;

    always_comb begin
        v_up = (r_s1_row == '0) ? '0 : (r_byp ? r_fwd : v_ram_rdata);
        v_dg = (r_s1_row == '0 || r_s1_col == '0) ? '0 : r_diag_size;
        v_lf = (r_s1_col == '0) ? '0 : r_left_size;
        v_min = v_up;
        if (v_dg < v_min) begin
            v_min = v_dg;
        end
        if (v_lf < v_min) begin
            v_min = v_lf;
        end
        if (r_s1_blocked) begin
            v_side = '0;
        end else if (v_min == SIZE_SAT) begin
            v_side = SIZE_SAT;
        end else begin
            v_side = v_min + SIZE_W'(1);
        end
    end

    always_comb begin
        v_better    = !v_s1_ovf && (v_side > r_best_size);
        v_row_calc  = 32'(r_s1_row) + 32'd1 - 32'(v_side);
        v_col_calc  = 32'(r_s1_col) + 32'd1 - 32'(v_side);
        n_best_size = v_better ? v_side : r_best_size;
        n_best_row  = v_better ? ROW_W'(v_row_calc) : r_best_row;
        n_best_col  = v_better ? COL_W'(v_col_calc) : r_best_col;
        n_overflow  = r_overflow || v_s1_ovf;
    end

    lesf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_s1_col),
        .i_wdata (v_side),
        .i_re    (v_accept),
        .i_raddr (r_col_count),
        .o_rdata (v_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= COLS_RESET;
            r_col_count <= '0;
            r_row_count <= '0;
            r_s1_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_left_size <= '0;
            r_diag_size <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_columns <= i_cfg.columns;
            end
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;

            if (v_accept) begin
                r_s1_valid <= 1'b1;
                r_byp      <= v_we && (r_s1_col == r_col_count);
            end else if (v_s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (v_s1_fire) begin
                if (r_s1_last) begin
                    r_left_size <= '0;
                    r_diag_size <= '0;
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                    r_overflow  <= 1'b0;
                end else begin
                    if (!v_s1_ovf) begin
                        r_left_size <= v_side;
                        r_diag_size <= v_up;
                    end
                    r_best_size <= n_best_size;
                    r_best_row  <= n_best_row;
                    r_best_col  <= n_best_col;
                    r_overflow  <= n_overflow;
                end
            end

            if (v_s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_s1_blocked <= i_cell.blocked;
            r_s1_last    <= i_cell.last_cell;
            r_s1_col     <= r_col_count;
            r_s1_row     <= r_row_count;
            r_fwd        <= v_side;
        end
        if (v_s1_fire && r_s1_last) begin
            r_out_size <= n_best_size;
            r_out_row  <= n_best_row;
            r_out_col  <= n_best_col;
            r_out_ovf  <= n_overflow;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.square_size = r_out_size;
    assign o_result.top_row     = r_out_row;
    assign o_result.left_col    = r_out_col;
    assign o_result.too_large   = r_out_ovf;

endmodule

@@ dv/largest_empty_square_checker.sv @@
// ----------------------------------------------------------------------------
// largest_empty_square_checker
// Watches the column, cell and result channels of the square finder, keeps
// its own copy of the line of square sides and the best square per map, and
// compares every result beat field by field with the oldest predicted square.
// ----------------------------------------------------------------------------
module largest_empty_square_checker
    import lesf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    lesf_cfg_if    i_cfg,
    lesf_cell_if   i_cell,
    lesf_result_if i_result,
    output int     o_errors,
    output int     o_pending
);

    typedef struct packed {
        logic [SIZE_W-1:0] square_size;
        logic [ROW_W-1:0]  top_row;
        logic [COL_W-1:0]  left_col;
        logic              too_large;
    } t_square;

    logic [COLS_W-1:0] columns_q;
    logic [SIZE_W-1:0] side_line [DEF_MAX_COLS];
    logic [SIZE_W-1:0] left_side;
    logic [SIZE_W-1:0] diag_side;
    logic [COL_W-1:0]  col_pos;
    logic [ROW_W:0]    row_pos;
    logic [SIZE_W-1:0] best_side;
    logic [ROW_W-1:0]  best_row;
    logic [COL_W-1:0]  best_col;
    logic              overflow_seen;
    t_square           expected_squares [$];
    int                error_count = 0;
    int                pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    task automatic clear_map();
        left_side     = '0;
        diag_side     = '0;
        col_pos       = '0;
        row_pos       = '0;
        best_side     = '0;
        best_row      = '0;
        best_col      = '0;
        overflow_seen = 1'b0;
    endtask

    task automatic scan_cell(input logic blocked, input logic last);
        int      width;
        int      up;
        int      diag;
        int      left;
        int      side;
        t_square found;
        if (columns_q == '0) begin
            width = 1;
        end else if (int'(columns_q) > DEF_MAX_COLS) begin
            width = DEF_MAX_COLS;
        end else begin
            width = int'(columns_q);
        end

        if (row_pos >= DEF_MAX_ROWS) begin
            overflow_seen = 1'b1;
        end else begin
            up   = (row_pos == 0) ? 0 : int'(side_line[col_pos]);
            diag = (row_pos == 0 || col_pos == 0) ? 0 : int'(diag_side);
            left = (col_pos == 0) ? 0 : int'(left_side);
            if (blocked) begin
                side = 0;
            end else begin
                side = up;
                if (diag < side) side = diag;
                if (left < side) side = left;
                side = (side >= 255) ? 255 : side + 1;
            end
            // only a strictly larger square moves the best one
            if (side > int'(best_side)) begin
                best_side = SIZE_W'(side);
                best_row  = ROW_W'(int'(row_pos) + 1 - side);
                best_col  = COL_W'(int'(col_pos) + 1 - side);
            end
            diag_side          = SIZE_W'(up);
            left_side          = SIZE_W'(side);
            side_line[col_pos] = SIZE_W'(side);
        end

        if (int'(col_pos) + 1 >= width) begin
            col_pos = '0;
            if (row_pos < DEF_MAX_ROWS) row_pos++;
        end else begin
            col_pos++;
        end

        if (last) begin
            found.square_size = best_side;
            found.top_row     = best_row;
            found.left_col    = best_col;
            found.too_large   = overflow_seen;
            expected_squares.push_back(found);
            clear_map();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_square got;
        t_square want;
        if (!i_rst_n) begin
            columns_q = COLS_RESET;
            foreach (side_line[i]) side_line[i] = '0;
            clear_map();
            expected_squares.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                columns_q = i_cfg.columns;
            end
            if (i_cell.valid && i_cell.ready) begin
                scan_cell(i_cell.blocked, i_cell.last_cell);
            end
            if (i_result.valid && i_result.ready) begin
                got.square_size = i_result.square_size;
                got.top_row     = i_result.top_row;
                got.left_col    = i_result.left_col;
                got.too_large   = i_result.too_large;
                if (expected_squares.size() == 0) begin
                    $error("result beat with no map pending: square_size %0d",
                           got.square_size);
                    error_count++;
                end else begin
                    want = expected_squares.pop_front();
                    if (got.square_size !== want.square_size) begin
                        $error("square_size: expected %0d, got %0d",
                               want.square_size, got.square_size);
                        error_count++;
                    end
                    if (got.top_row !== want.top_row) begin
                        $error("top_row: expected %0d, got %0d", want.top_row, got.top_row);
                        error_count++;
                    end
                    if (got.left_col !== want.left_col) begin
                        $error("left_col: expected %0d, got %0d", want.left_col, got.left_col);
                        error_count++;
                    end
                    if (got.too_large !== want.too_large) begin
                        $error("too_large: expected %0d, got %0d",
                               want.too_large, got.too_large);
                        error_count++;
                    end
                end
            end
        end
        pending_count = expected_squares.size();
    end

endmodule

@@ dv/largest_empty_square_finder_tb.sv @@
// ----------------------------------------------------------------------------
// largest_empty_square_finder_tb
// Streams binary maps into the square finder: short hand-written maps first,
// then row-width extremes, too-tall maps and random maps of random density,
// with bursty cell beats and a result side that stalls, once for a long
// stretch. The checker predicts each map's square and counts mismatches.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_tb;
    import lesf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CELL_TARGET  = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   error_count;
    int   maps_pending;
    int   quiet_cycles = 0;
    int   cells_sent   = 0;
    int   burst_left   = 0;
    bit   no_gaps      = 1'b0;
    bit   hold_request = 1'b0;

    lesf_cfg_if    cfg_ch ();
    lesf_cell_if   cell_ch ();
    lesf_result_if res_ch ();

    largest_empty_square_finder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_cell   (cell_ch),
        .o_result (res_ch)
    );

    largest_empty_square_checker u_square_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_ch),
        .i_cell    (cell_ch),
        .i_result  (res_ch),
        .o_errors  (error_count),
        .o_pending (maps_pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int row_width(input logic [COLS_W-1:0] setting);
        if (setting == '0) return 1;
        if (int'(setting) > DEF_MAX_COLS) return DEF_MAX_COLS;
        return int'(setting);
    endfunction

    task automatic send_cell(input logic blocked, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                cell_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        cell_ch.valid     <= 1'b1;
        cell_ch.blocked   <= blocked;
        cell_ch.last_cell <= last;
        do @(posedge i_clk); while (!cell_ch.ready);
        burst_left--;
        cells_sent++;
    endtask

    task automatic send_map(input int count, input int empty_pct);
        for (int i = 0; i < count; i++) begin
            send_cell($urandom_range(0, 99) >= empty_pct, i == count - 1);
        end
    endtask

    // B is a blocked cell, anything else empty; the last one closes the map
    task automatic send_pattern(input string pattern);
        for (int i = 0; i < pattern.len(); i++) begin
            send_cell(pattern[i] == "B", i == pattern.len() - 1);
        end
    endtask

    task automatic settle();
        cell_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (maps_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_columns(input logic [COLS_W-1:0] value);
        cfg_ch.columns <= value;
        cfg_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int                width;
        int                rows;
        int                count;
        int                empty_pct;
        logic [COLS_W-1:0] setting;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.columns    <= COLS_RESET;
        cell_ch.valid     <= 1'b0;
        cell_ch.blocked   <= 1'b0;
        cell_ch.last_cell <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset width, maps closing mid-row
        send_pattern("B");
        send_pattern("E");
        send_pattern("BBEEB");
        send_pattern("EBE");
        settle();
        write_columns('0);
        send_pattern("EEEBE");
        settle();
        write_columns(COLS_W'(2));
        send_pattern("EEEE");
        send_pattern("BEEEEE");
        settle();

        // tiny maps while the result side holds off
        write_columns(COLS_W'(3));
        hold_request = 1'b1;
        repeat (120) send_map($urandom_range(1, 3), 70);
        settle();

        // square in the last allowed row, then a map that is too tall
        write_columns(COLS_W'(1));
        for (int i = 0; i < DEF_MAX_ROWS; i++) begin
            send_cell(i != DEF_MAX_ROWS - 1, i == DEF_MAX_ROWS - 1);
        end
        send_map(DEF_MAX_ROWS + 7, 90);
        settle();

        // square in the last column of the widest row
        write_columns(COLS_W'(DEF_MAX_COLS));
        for (int i = 0; i < DEF_MAX_COLS; i++) begin
            send_cell(i != DEF_MAX_COLS - 1, i == DEF_MAX_COLS - 1);
        end
        settle();
        write_columns(COLS_W'(511));
        send_map(300, 95);
        settle();

        while (cells_sent < CELL_TARGET) begin
            case ($urandom_range(0, 9))
                0: setting = '0;
                1: setting = COLS_W'(1);
                2: setting = COLS_W'($urandom_range(DEF_MAX_COLS + 1, 511));
                3: setting = COLS_W'(DEF_MAX_COLS);
                default: setting = COLS_W'($urandom_range(2, 12));
            endcase
            width = row_width(setting);
            write_columns(setting);
            repeat ((width >= 64) ? 1 : $urandom_range(1, 4)) begin
                no_gaps   = ($urandom_range(0, 3) == 0);
                empty_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(40, 97);
                if (width >= 64) begin
                    count = $urandom_range(1, width + 24);
                end else if (width <= 2 && $urandom_range(0, 5) == 0) begin
                    count = width * $urandom_range(DEF_MAX_ROWS + 1, DEF_MAX_ROWS + 6);
                end else begin
                    rows  = $urandom_range(1, width + 3);
                    count = rows * width;
                    if (width > 1 && $urandom_range(0, 2) == 0) begin
                        count += $urandom_range(1, width - 1);
                    end
                end
                send_map(count, empty_pct);
            end
            settle();
        end

        if (error_count == 0) begin
            $display("largest_empty_square_finder test passed");
        end else begin
            $display("largest_empty_square_finder test failed");
        end
        $finish;
    end

    initial begin : result_sink
        bit hold_done;
        int mode;
        int span;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= (k % 4 == 3);
                    default: res_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cfg_ch.valid && cfg_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("largest_empty_square_finder test failed");
        $finish;
    end

endmodule
